// File: rtl/mi4c_pkg.sv
// Shared types, constants and cofactor index tables for the 4x4 matrix inverse.
// Used by mi4c_ctrl, mi4c_dp and matrix_inverse_4x4_cofactor; no dependencies.
`timescale 1ns / 1ps
package mi4c_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int COF_W      = 64;
  localparam int HALF_W     = COF_W / 2;
  localparam int OPW        = ((DATA_WIDTH > HALF_W) ? DATA_WIDTH : HALF_W) + 1;
  localparam int MUL_W      = 2 * OPW;
  localparam int PROD_W     = COF_W + DATA_WIDTH + 1;
  localparam int ACC_W      = PROD_W + 4;
  localparam int NUM_W      = COF_W + FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_EMIT_INVERSE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SINGULAR_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET       = CFG_DATA_W'(7);

  localparam logic [DATA_WIDTH-1:0] ID_ONE = (FRAC_BITS < DATA_WIDTH - 1) ?
      (DATA_WIDTH'(1) << FRAC_BITS) : {1'b0, {(DATA_WIDTH-1){1'b1}}};

  localparam int NUM_PAIRS = 24;
  localparam logic [4:0] LAST_PAIR = 5'(NUM_PAIRS - 1);

  localparam logic [3:0] PAIR_A [12] = '{4'd10, 4'd11, 4'd9, 4'd11, 4'd9, 4'd10,
                                         4'd8, 4'd11, 4'd8, 4'd10, 4'd8, 4'd9};
  localparam logic [3:0] PAIR_B [12] = '{4'd15, 4'd14, 4'd15, 4'd13, 4'd14, 4'd13,
                                         4'd15, 4'd12, 4'd14, 4'd12, 4'd13, 4'd12};

  localparam logic [3:0] TERM_PAIR [8][6] = '{
    '{4'd0, 4'd3, 4'd4,  4'd1, 4'd2, 4'd5},  '{4'd1, 4'd6, 4'd9,  4'd0, 4'd7, 4'd8},
    '{4'd2, 4'd7, 4'd10, 4'd3, 4'd6, 4'd11}, '{4'd5, 4'd8, 4'd11, 4'd4, 4'd9, 4'd10},
    '{4'd1, 4'd2, 4'd5,  4'd0, 4'd3, 4'd4},  '{4'd0, 4'd7, 4'd8,  4'd1, 4'd6, 4'd9},
    '{4'd3, 4'd6, 4'd11, 4'd2, 4'd7, 4'd10}, '{4'd4, 4'd9, 4'd10, 4'd5, 4'd8, 4'd11}
  };
  localparam logic [3:0] TERM_ELEM [8][6] = '{
    '{4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7}, '{4'd4, 4'd6, 4'd7, 4'd4, 4'd6, 4'd7},
    '{4'd4, 4'd5, 4'd7, 4'd4, 4'd5, 4'd7}, '{4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd6},
    '{4'd1, 4'd2, 4'd3, 4'd1, 4'd2, 4'd3}, '{4'd0, 4'd2, 4'd3, 4'd0, 4'd2, 4'd3},
    '{4'd0, 4'd1, 4'd3, 4'd0, 4'd1, 4'd3}, '{4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2}
  };

  typedef enum logic [1:0] {MUL_PAIR, MUL_TERM, MUL_DLO, MUL_DHI} mul_sel_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_PAIR_WR, DP_ACC_ADD, DP_ACC_SUB, DP_COF_WR, DP_PROD_LO, DP_PROD_HI,
    DP_ACC_PROD, DP_DET, DP_DIV_LOAD, DP_DIV_STEP, DP_OUT_DIV, DP_OUT_IDENT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_LOAD, S_PAIR, S_TERM, S_COFWR, S_DET, S_DETFIN, S_EMIT, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic       elem_we;
    logic [3:0] elem_wa;
    logic       rd_en;
    logic [3:0] elem_ra0;
    logic [3:0] elem_ra1;
    logic [4:0] pair_ra;
    logic [3:0] cof_ra;
    logic [4:0] pair_wa;
    logic [3:0] cof_wa;
    mul_sel_t   mul_sel;
    dp_op_t     op;
    logic [3:0] out_index;
  } dp_cmd_t;

  typedef struct packed {
    logic singular;
    logic emit_inverse;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/matrix_inverse_4x4_cofactor.sv
// Top level of the 4x4 matrix inverse by cofactor expansion.
// Instantiates mi4c_ctrl and mi4c_dp; depends on mi4c_pkg.
//
// Input channel: one beat per matrix element, row-major, signed Q16.16, on
// in_valid / in_stall / in_element_value. After the sixteenth beat the block
// stalls its input while it computes and emits sixteen result beats on
// out_valid / out_stall, each with value, row-major index, singular flag and
// last on the sixteenth beat.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 emit_inverse,
// 1 singular_threshold) and cfg_data; cfg_ready is always high.
// After the sixteenth element the sequencer forms pair products, cofactor
// accumulation and the determinant, all on one shared 33x33 multiplier.
// Each result of a non-singular matrix then comes from the bit-serial
// restoring divider (81 steps per quotient); a singular matrix emits one
// identity beat per cycle while the output is not stalled.
// Reset clears the load count, emit_inverse and output valid and sets the
// singular threshold to 7. A stalled receiver holds the output register
// and the sequencer waits before each further result beat.
`timescale 1ns / 1ps
module matrix_inverse_4x4_cofactor (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mi4c_pkg::DATA_WIDTH-1:0] in_element_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mi4c_pkg::DATA_WIDTH-1:0] out_result_value,
  output logic [3:0]                             out_result_index,
  output logic                                   out_singular,
  output logic                                   out_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mi4c_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mi4c_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import mi4c_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mi4c_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mi4c_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_element_value (in_element_value),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_result_index (out_result_index),
    .out_singular     (out_singular),
    .out_last         (out_last)
  );

endmodule

// File: rtl/mi4c_ctrl.sv
// Sequencer for the 4x4 matrix inverse: load, pair products, cofactors,
// determinant, per-element division and emit. Depends on mi4c_pkg.
`timescale 1ns / 1ps
module mi4c_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mi4c_pkg::dp_status_t status,
  output mi4c_pkg::dp_cmd_t    cmd
);
  import mi4c_pkg::*;

  state_t               state_r, state_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [4:0]           k_r, k_nxt;
  logic [2:0]           t_r, t_nxt;
  logic [3:0]           load_cnt_r, load_cnt_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic       pair_hi;
  logic [4:0] pair_idx_w;
  logic [3:0] pair_idx, pair_ofs;
  logic       h2;
  logic [2:0] row;
  logic [4:0] term_pair_ra;
  logic [3:0] term_elem_ra, emit_src;

  assign pair_hi      = (k_r >= 5'd12);
  assign pair_idx_w   = pair_hi ? (k_r - 5'd12) : k_r;
  assign pair_idx     = pair_idx_w[3:0];
  assign pair_ofs     = pair_hi ? 4'd8 : 4'd0;
  assign h2           = k_r[3];
  assign row          = k_r[2:0];
  assign term_pair_ra = (h2 ? 5'd12 : 5'd0) + {1'b0, TERM_PAIR[row][t_r]};
  assign term_elem_ra = TERM_ELEM[row][t_r] + {h2, 3'b000};
  assign emit_src     = status.emit_inverse ? {k_r[1:0], k_r[3:2]} : k_r[3:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      step_r     <= 3'd0;
      k_r        <= 5'd0;
      t_r        <= 3'd0;
      load_cnt_r <= 4'd0;
      div_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      k_r        <= k_nxt;
      t_r        <= t_nxt;
      load_cnt_r <= load_cnt_nxt;
      div_cnt_r  <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    k_nxt        = k_r;
    t_nxt        = t_r;
    load_cnt_nxt = load_cnt_r;
    div_cnt_nxt  = div_cnt_r;
    in_stall     = 1'b1;
    cmd          = '0;
    cmd.mul_sel  = MUL_PAIR;
    cmd.op       = DP_NOP;
    cmd.elem_wa  = load_cnt_r;
    cmd.out_index = k_r[3:0];
    unique case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.elem_we  = 1'b1;
          load_cnt_nxt = load_cnt_r + 4'd1;
          if (load_cnt_r == 4'd15) begin
            state_nxt = S_PAIR;
            k_nxt     = 5'd0;
            step_nxt  = 3'd0;
          end
        end
      end
      S_PAIR: begin
        unique case (step_r)
          3'd0: begin
            cmd.rd_en    = 1'b1;
            cmd.elem_ra0 = PAIR_A[pair_idx] - pair_ofs;
            cmd.elem_ra1 = PAIR_B[pair_idx] - pair_ofs;
            step_nxt     = 3'd1;
          end
          3'd1: begin
            cmd.mul_sel = MUL_PAIR;
            step_nxt    = 3'd2;
          end
          default: begin
            cmd.op      = DP_PAIR_WR;
            cmd.pair_wa = k_r;
            step_nxt    = 3'd0;
            if (k_r == LAST_PAIR) begin
              state_nxt = S_TERM;
              k_nxt     = 5'd0;
              t_nxt     = 3'd0;
            end else begin
              k_nxt = k_r + 5'd1;
            end
          end
        endcase
      end
      S_TERM: begin
        unique case (step_r)
          3'd0: begin
            cmd.rd_en    = 1'b1;
            cmd.pair_ra  = term_pair_ra;
            cmd.elem_ra0 = term_elem_ra;
            step_nxt     = 3'd1;
          end
          3'd1: begin
            cmd.mul_sel = MUL_TERM;
            step_nxt    = 3'd2;
          end
          default: begin
            cmd.op   = (t_r < 3'd3) ? DP_ACC_ADD : DP_ACC_SUB;
            step_nxt = 3'd0;
            if (t_r == 3'd5) state_nxt = S_COFWR;
            else t_nxt = t_r + 3'd1;
          end
        endcase
      end
      S_COFWR: begin
        cmd.op     = DP_COF_WR;
        cmd.cof_wa = k_r[3:0];
        t_nxt      = 3'd0;
        if (k_r == 5'd15) begin
          state_nxt = S_DET;
          k_nxt     = 5'd0;
        end else begin
          state_nxt = S_TERM;
          k_nxt     = k_r + 5'd1;
        end
      end
      S_DET: begin
        unique case (step_r)
          3'd0: begin
            cmd.rd_en    = 1'b1;
            cmd.elem_ra0 = k_r[3:0];
            cmd.cof_ra   = k_r[3:0];
            step_nxt     = 3'd1;
          end
          3'd1: begin
            cmd.mul_sel = MUL_DLO;
            step_nxt    = 3'd2;
          end
          3'd2: begin
            cmd.mul_sel = MUL_DHI;
            cmd.op      = DP_PROD_LO;
            step_nxt    = 3'd3;
          end
          3'd3: begin
            cmd.op   = DP_PROD_HI;
            step_nxt = 3'd4;
          end
          default: begin
            cmd.op   = DP_ACC_PROD;
            step_nxt = 3'd0;
            if (k_r == 5'd3) state_nxt = S_DETFIN;
            else k_nxt = k_r + 5'd1;
          end
        endcase
      end
      S_DETFIN: begin
        cmd.op    = DP_DET;
        k_nxt     = 5'd0;
        step_nxt  = 3'd0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.singular) begin
          if (status.out_free) begin
            cmd.op = DP_OUT_IDENT;
            if (k_r == 5'd15) state_nxt = S_LOAD;
            else k_nxt = k_r + 5'd1;
          end
        end else if (step_r == 3'd0) begin
          cmd.rd_en  = 1'b1;
          cmd.cof_ra = emit_src;
          step_nxt   = 3'd1;
        end else begin
          cmd.op      = DP_DIV_LOAD;
          div_cnt_nxt = '0;
          step_nxt    = 3'd0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op      = DP_DIV_STEP;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(NUM_W - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op = DP_OUT_DIV;
          if (k_r == 5'd15) begin
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 5'd1;
            state_nxt = S_EMIT;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_OUT_DIV || cmd.op == DP_OUT_IDENT) |-> status.out_free)
    else $error("result issued while output register busy");
  a_no_div_singular: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_DIV_STEP) |-> !status.singular)
    else $error("division step on singular matrix");
  a_detfin_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DETFIN) |=> (state_r == S_EMIT && k_r == 5'd0))
    else $error("determinant not followed by emit");
  a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (in_stall && !cmd.elem_we))
    else $error("element written outside load");

endmodule

// File: rtl/mi4c_dp.sv
// Datapath for the 4x4 matrix inverse: element, pair and cofactor memories,
// shared multiplier, accumulator, serial divider, config and output register.
`timescale 1ns / 1ps
module mi4c_dp (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  mi4c_pkg::dp_cmd_t                          cmd,
  output mi4c_pkg::dp_status_t                       status,
  input  logic signed [mi4c_pkg::DATA_WIDTH-1:0]     in_element_value,
  input  logic                                       cfg_valid,
  input  logic [mi4c_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [mi4c_pkg::CFG_DATA_W-1:0]            cfg_data,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [mi4c_pkg::DATA_WIDTH-1:0]     out_result_value,
  output logic [3:0]                                 out_result_index,
  output logic                                       out_singular,
  output logic                                       out_last
);
  import mi4c_pkg::*;

  localparam logic signed [MUL_W-1:0]  M_HALF = MUL_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [DATA_WIDTH-1:0] W_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] W_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] elem_mem [16];
  logic signed [DATA_WIDTH-1:0] pair_mem [NUM_PAIRS];
  logic signed [COF_W-1:0]      cof_mem  [16];

  logic signed [DATA_WIDTH-1:0] ea_q, eb_q, pr_q;
  logic signed [COF_W-1:0]      cf_q;

  logic                  emit_inv_r;
  logic [CFG_DATA_W-1:0] thr_r;

  logic signed [OPW-1:0]    mul_a, mul_b;
  logic signed [MUL_W-1:0]  mul_r, mul_sum, mul_rnd;
  logic signed [PROD_W-1:0] prod_r, prod_sum, prod_rnd;
  logic signed [ACC_W-1:0]  acc_r;
  logic [DATA_WIDTH-1:0]    pair_sat;
  logic signed [COF_W-1:0]  acc_sat;
  logic [COF_W-1:0]         acc_mag, cf_mag;

  logic                sing_r, det_neg_r, neg_r;
  logic [COF_W-1:0]    det_mag_r, rem_r;
  logic [NUM_W-1:0]    num_r, quo_r;
  logic [COF_W:0]      rem_sh;
  logic                q_ge;
  logic                pos_over, neg_over;
  logic [DATA_WIDTH-1:0] quo_neg, div_val, ident_val;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_value_r;
  logic [3:0]            out_index_r;
  logic                  out_sing_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_inv_r <= 1'b0;
      thr_r      <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_EMIT_INVERSE) emit_inv_r <= cfg_data[0];
      else if (cfg_index == REG_SINGULAR_THRESHOLD) thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.elem_we) elem_mem[cmd.elem_wa] <= in_element_value;
    if (cmd.op == DP_PAIR_WR) pair_mem[cmd.pair_wa] <= pair_sat;
    if (cmd.op == DP_COF_WR) cof_mem[cmd.cof_wa] <= acc_sat;
    if (cmd.rd_en) begin
      ea_q <= elem_mem[cmd.elem_ra0];
      eb_q <= elem_mem[cmd.elem_ra1];
      pr_q <= pair_mem[cmd.pair_ra];
      cf_q <= cof_mem[cmd.cof_ra];
    end
  end

  assign mul_a = OPW'(ea_q);
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_PAIR: mul_b = OPW'(eb_q);
      MUL_TERM: mul_b = OPW'(pr_q);
      MUL_DLO:  mul_b = OPW'($signed({1'b0, cf_q[HALF_W-1:0]}));
      MUL_DHI:  mul_b = OPW'($signed(cf_q[COF_W-1:HALF_W]));
      default:  mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  assign mul_sum  = mul_r + M_HALF;
  assign mul_rnd  = mul_sum >>> FRAC_BITS;
  assign pair_sat = (&mul_rnd[MUL_W-1:DATA_WIDTH-1] || ~|mul_rnd[MUL_W-1:DATA_WIDTH-1]) ?
                    mul_rnd[DATA_WIDTH-1:0] : (mul_rnd[MUL_W-1] ? W_MIN : W_MAX);
  assign prod_sum = prod_r + P_HALF;
  assign prod_rnd = prod_sum >>> FRAC_BITS;
  assign acc_sat  = (&acc_r[ACC_W-1:COF_W-1] || ~|acc_r[ACC_W-1:COF_W-1]) ?
                    acc_r[COF_W-1:0] :
                    (acc_r[ACC_W-1] ? {1'b1, {(COF_W-1){1'b0}}} : {1'b0, {(COF_W-1){1'b1}}});
  assign acc_mag  = acc_sat[COF_W-1] ? (~acc_sat + COF_W'(1)) : acc_sat;
  assign cf_mag   = cf_q[COF_W-1] ? (~cf_q + COF_W'(1)) : cf_q;

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign q_ge   = (rem_sh >= {1'b0, det_mag_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      sing_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        DP_ACC_ADD:  acc_r <= acc_r + ACC_W'(mul_rnd);
        DP_ACC_SUB:  acc_r <= acc_r - ACC_W'(mul_rnd);
        DP_COF_WR:   acc_r <= '0;
        DP_ACC_PROD: acc_r <= acc_r + ACC_W'(prod_rnd);
        DP_DET: begin
          acc_r  <= '0;
          sing_r <= (acc_sat == '0) || (acc_mag < COF_W'(thr_r));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_PROD_LO: prod_r <= PROD_W'(mul_r);
      DP_PROD_HI: prod_r <= prod_r + (PROD_W'(mul_r) <<< HALF_W);
      DP_DET: begin
        det_neg_r <= acc_sat[COF_W-1];
        det_mag_r <= acc_mag;
      end
      DP_DIV_LOAD: begin
        num_r <= NUM_W'({cf_mag, {FRAC_BITS{1'b0}}}) + NUM_W'(det_mag_r >> 1);
        neg_r <= cf_q[COF_W-1] ^ det_neg_r;
        rem_r <= '0;
        quo_r <= '0;
      end
      DP_DIV_STEP: begin
        rem_r <= q_ge ? COF_W'(rem_sh - {1'b0, det_mag_r}) : rem_sh[COF_W-1:0];
        num_r <= num_r << 1;
        quo_r <= {quo_r[NUM_W-2:0], q_ge};
      end
      default: ;
    endcase
  end

  assign pos_over  = |quo_r[NUM_W-1:DATA_WIDTH-1];
  assign neg_over  = (|quo_r[NUM_W-1:DATA_WIDTH]) ||
                     (quo_r[DATA_WIDTH-1] && |quo_r[DATA_WIDTH-2:0]);
  assign quo_neg   = ~quo_r[DATA_WIDTH-1:0] + DATA_WIDTH'(1);
  assign div_val   = neg_r ? (neg_over ? W_MIN : quo_neg)
                           : (pos_over ? W_MAX : quo_r[DATA_WIDTH-1:0]);
  assign ident_val = (cmd.out_index == 4'd0 || cmd.out_index == 4'd5 ||
                      cmd.out_index == 4'd10 || cmd.out_index == 4'd15) ? ID_ONE : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_OUT_DIV || cmd.op == DP_OUT_IDENT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT_DIV || cmd.op == DP_OUT_IDENT) begin
      out_value_r <= (cmd.op == DP_OUT_IDENT) ? ident_val : div_val;
      out_index_r <= cmd.out_index;
      out_sing_r  <= (cmd.op == DP_OUT_IDENT);
      out_last_r  <= (cmd.out_index == 4'd15);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_index = out_index_r;
  assign out_singular     = out_sing_r;
  assign out_last         = out_last_r;

  assign status.singular     = sing_r;
  assign status.emit_inverse = emit_inv_r;
  assign status.out_free     = !out_valid_r || !out_stall;

endmodule
